// File: src/gha_pkg.sv
// Shared types and constants for the generational handle allocator.
package gha_pkg;

  localparam int unsigned SLOTS_DEF    = 1024;
  localparam int unsigned GEN_BITS_DEF = 8;

  // Fixed widths of the request and response fields
  localparam int unsigned IDX_W = 10;
  localparam int unsigned GEN_W = 8;

  typedef enum logic [1:0] {
    ACT_CREATE  = 2'd0,
    ACT_DESTROY = 2'd1,
    ACT_CHECK   = 2'd2,
    ACT_NOP     = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_SLOT    = 2'd1,
    ST_NOT_ISSUED = 2'd2,
    ST_QUEUE_FULL = 2'd3
  } status_e;

  // What the resolve stage does with the generation read from the table
  typedef enum logic [2:0] {
    OP_ZERO    = 3'd0,  // answer generation 0, no write
    OP_FRESH   = 3'd1,  // new slot: write 0, answer 0
    OP_STORED  = 3'd2,  // answer stored generation
    OP_DESTROY = 3'd3,  // write stored + 1, answer the new value
    OP_CHECK   = 3'd4   // answer stored generation and compare
  } op_e;

  typedef struct packed {
    logic              valid;
    op_e               op;
    status_e           status;
    logic [IDX_W-1:0]  index;
    logic [GEN_W-1:0]  gen;
  } s2_ctrl_t;

endpackage

// File: src/gha_if.sv
// Request and response channel interfaces of the handle allocator.
interface gha_req_if import gha_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       action;
  logic [IDX_W-1:0] slot_index;
  logic [GEN_W-1:0] slot_generation;

  modport source (output valid, output action, output slot_index, output slot_generation,
                  input ready);
  modport sink   (input valid, input action, input slot_index, input slot_generation,
                  output ready);
endinterface

interface gha_rsp_if import gha_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] handle_index;
  logic [GEN_W-1:0] handle_generation;
  logic             is_alive;
  logic [1:0]       status;

  modport source (output valid, output handle_index, output handle_generation,
                  output is_alive, output status, input ready);
  modport sink   (input valid, input handle_index, input handle_generation,
                  input is_alive, input status, output ready);
endinterface

// File: src/generational_handle_allocator_top.sv
// Path: a request's response reaches the output through the input register, the generation
//   table read and the result register, and is held there while the response side stalls.
// Throughput: one request per cycle while the response side takes responses; ready follows
//   the response side through one gate.
// Reset: counters, free queue pointers and valid flags clear at once; no clearing pass,
//   since a slot's generation is written to zero when the slot is first issued.
module generational_handle_allocator_top import gha_pkg::*; #(
  parameter int unsigned SLOTS    = SLOTS_DEF,
  parameter int unsigned GEN_BITS = GEN_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  gha_req_if.sink  req_i,
  gha_rsp_if.source rsp_o
);

  localparam int unsigned IW = $clog2(SLOTS);

  logic adv;

  // free queue of destroyed slot indices
  logic          fq_we;
  logic [IW-1:0] fq_waddr, fq_wdata, fq_raddr, fq_head;

  // generation table, one entry per slot
  logic                gen_we;
  logic [IW-1:0]       gen_waddr, gen_raddr;
  logic [GEN_BITS-1:0] gen_wdata, gen_rdata;

  s2_ctrl_t      s2_ctrl;
  logic [IW-1:0] s2_addr;
  status_e       rsp_status;

  // Whole pipeline moves together; a bubble in the resolve stage lets it close up
  assign req_i.ready = adv;

  gha_issue #(
    .SLOTS (SLOTS)
  ) u_issue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .req_valid_i  (req_i.valid),
    .req_action_i (req_i.action),
    .req_index_i  (req_i.slot_index),
    .req_gen_i    (req_i.slot_generation),
    .fq_head_i    (fq_head),
    .fq_we_o      (fq_we),
    .fq_waddr_o   (fq_waddr),
    .fq_wdata_o   (fq_wdata),
    .fq_raddr_o   (fq_raddr),
    .gen_raddr_o  (gen_raddr),
    .s2_ctrl_o    (s2_ctrl),
    .s2_addr_o    (s2_addr)
  );

  // Head entry is prefetched so a create can pop without waiting on the RAM
  gha_ram #(
    .DEPTH (SLOTS),
    .WIDTH (IW)
  ) u_free_queue (
    .clk_i   (clk_i),
    .we_i    (fq_we),
    .waddr_i (fq_waddr),
    .wdata_i (fq_wdata),
    .re_i    (adv),
    .raddr_i (fq_raddr),
    .rdata_o (fq_head)
  );

  // Read in the issue stage, written back by the resolve stage; the RAM's
  // write-through covers a request that reads the slot just being updated
  gha_ram #(
    .DEPTH (SLOTS),
    .WIDTH (GEN_BITS)
  ) u_gen_table (
    .clk_i   (clk_i),
    .we_i    (gen_we),
    .waddr_i (gen_waddr),
    .wdata_i (gen_wdata),
    .re_i    (adv),
    .raddr_i (gen_raddr),
    .rdata_o (gen_rdata)
  );

  gha_resolve #(
    .SLOTS    (SLOTS),
    .GEN_BITS (GEN_BITS)
  ) u_resolve (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s2_ctrl_i    (s2_ctrl),
    .s2_addr_i    (s2_addr),
    .gen_rdata_i  (gen_rdata),
    .rsp_ready_i  (rsp_o.ready),
    .adv_o        (adv),
    .gen_we_o     (gen_we),
    .gen_waddr_o  (gen_waddr),
    .gen_wdata_o  (gen_wdata),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_index_o  (rsp_o.handle_index),
    .rsp_gen_o    (rsp_o.handle_generation),
    .rsp_alive_o  (rsp_o.is_alive),
    .rsp_status_o (rsp_status)
  );

  assign rsp_o.status = rsp_status;

endmodule

// File: src/gha_ram.sv
// Simple dual-port RAM, one write and one registered read, write-through on collision.
module gha_ram import gha_pkg::*; #(
  parameter int unsigned DEPTH = SLOTS_DEF,
  parameter int unsigned WIDTH = GEN_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      // same-cycle write to the read address wins
      rdata_q <= (we_i && (waddr_i == raddr_i)) ? wdata_i : mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/gha_issue.sv
// Input register and issue stage: counters, free queue pointers, request decode.
module gha_issue import gha_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  logic                     req_valid_i,
  input  logic [1:0]               req_action_i,
  input  logic [IDX_W-1:0]         req_index_i,
  input  logic [GEN_W-1:0]         req_gen_i,
  input  logic [$clog2(SLOTS)-1:0] fq_head_i,
  output logic                     fq_we_o,
  output logic [$clog2(SLOTS)-1:0] fq_waddr_o,
  output logic [$clog2(SLOTS)-1:0] fq_wdata_o,
  output logic [$clog2(SLOTS)-1:0] fq_raddr_o,
  output logic [$clog2(SLOTS)-1:0] gen_raddr_o,
  output s2_ctrl_t                 s2_ctrl_o,
  output logic [$clog2(SLOTS)-1:0] s2_addr_o
);

  localparam int unsigned IW   = $clog2(SLOTS);
  localparam int unsigned CW   = $clog2(SLOTS + 1);
  localparam int unsigned CMPW = (CW > IDX_W) ? CW : IDX_W;
  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);
  localparam logic [CW-1:0] FULL = CW'(SLOTS);

  logic             s1_valid_q;
  logic [1:0]       s1_action_q;
  logic [IDX_W-1:0] s1_index_q;
  logic [GEN_W-1:0] s1_gen_q;

  logic [CW-1:0] issued_q, free_cnt_q;
  logic [IW-1:0] head_q, tail_q, head_nxt, tail_nxt;

  s2_ctrl_t      s2_ctrl_q, s2_ctrl_d;
  logic [IW-1:0] s2_addr_q, addr;

  logic go, fresh, push, pop, in_range;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv_i) begin
      s1_valid_q <= req_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && req_valid_i) begin
      s1_action_q <= req_action_i;
      s1_index_q  <= req_index_i;
      s1_gen_q    <= req_gen_i;
    end
  end

  assign head_nxt = (head_q == LAST) ? '0 : head_q + 1'b1;
  assign tail_nxt = (tail_q == LAST) ? '0 : tail_q + 1'b1;
  assign in_range = CMPW'(s1_index_q) < CMPW'(issued_q);

  always_comb begin
    s2_ctrl_d        = '0;
    s2_ctrl_d.valid  = s1_valid_q;
    s2_ctrl_d.op     = OP_ZERO;
    s2_ctrl_d.status = ST_OK;
    s2_ctrl_d.index  = s1_index_q;
    s2_ctrl_d.gen    = s1_gen_q;
    addr             = IW'(s1_index_q);
    fresh            = 1'b0;
    push             = 1'b0;
    pop              = 1'b0;
    unique case (action_e'(s1_action_q))
      ACT_CREATE: begin
        if (issued_q < FULL) begin
          s2_ctrl_d.op    = OP_FRESH;
          s2_ctrl_d.index = IDX_W'(issued_q);
          addr            = IW'(issued_q);
          fresh           = 1'b1;
        end else if (free_cnt_q != '0) begin
          s2_ctrl_d.op    = OP_STORED;
          s2_ctrl_d.index = IDX_W'(fq_head_i);
          addr            = fq_head_i;
          pop             = 1'b1;
        end else begin
          s2_ctrl_d.status = ST_NO_SLOT;
          s2_ctrl_d.index  = '0;
        end
      end
      ACT_DESTROY: begin
        if (!in_range) begin
          s2_ctrl_d.status = ST_NOT_ISSUED;
        end else if (free_cnt_q == FULL) begin
          s2_ctrl_d.op     = OP_STORED;
          s2_ctrl_d.status = ST_QUEUE_FULL;
        end else begin
          s2_ctrl_d.op = OP_DESTROY;
          push         = 1'b1;
        end
      end
      ACT_CHECK: begin
        if (!in_range) begin
          s2_ctrl_d.status = ST_NOT_ISSUED;
        end else begin
          s2_ctrl_d.op = OP_CHECK;
        end
      end
      ACT_NOP: begin
      end
    endcase
  end

  assign go = adv_i && s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issued_q   <= '0;
      free_cnt_q <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      s2_ctrl_q  <= '0;
    end else begin
      if (go && fresh) begin
        issued_q <= issued_q + 1'b1;
      end
      if (go && push) begin
        tail_q     <= tail_nxt;
        free_cnt_q <= free_cnt_q + 1'b1;
      end
      if (go && pop) begin
        head_q     <= head_nxt;
        free_cnt_q <= free_cnt_q - 1'b1;
      end
      if (adv_i) begin
        s2_ctrl_q <= s2_ctrl_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s2_addr_q <= addr;
    end
  end

  // free queue: push at tail, prefetch the entry at the next head
  assign fq_we_o     = go && push;
  assign fq_waddr_o  = tail_q;
  assign fq_wdata_o  = IW'(s1_index_q);
  assign fq_raddr_o  = (go && pop) ? head_nxt : head_q;
  assign gen_raddr_o = addr;
  assign s2_ctrl_o   = s2_ctrl_q;
  assign s2_addr_o   = s2_addr_q;

endmodule

// File: src/gha_resolve.sv
// Resolve stage: generation update and compare, result register and output handshake.
module gha_resolve import gha_pkg::*; #(
  parameter int unsigned SLOTS    = SLOTS_DEF,
  parameter int unsigned GEN_BITS = GEN_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  s2_ctrl_t                 s2_ctrl_i,
  input  logic [$clog2(SLOTS)-1:0] s2_addr_i,
  input  logic [GEN_BITS-1:0]      gen_rdata_i,
  input  logic                     rsp_ready_i,
  output logic                     adv_o,
  output logic                     gen_we_o,
  output logic [$clog2(SLOTS)-1:0] gen_waddr_o,
  output logic [GEN_BITS-1:0]      gen_wdata_o,
  output logic                     rsp_valid_o,
  output logic [IDX_W-1:0]         rsp_index_o,
  output logic [GEN_W-1:0]         rsp_gen_o,
  output logic                     rsp_alive_o,
  output status_e                  rsp_status_o
);

  localparam int unsigned GW = (GEN_BITS > GEN_W) ? GEN_BITS : GEN_W;

  logic                out_valid_q;
  logic [IDX_W-1:0]    out_index_q;
  logic [GEN_W-1:0]    out_gen_q;
  logic                out_alive_q;
  status_e             out_status_q;

  logic                load;
  logic [GEN_BITS-1:0] g_inc, g_out;
  logic                alive;

  assign adv_o = !s2_ctrl_i.valid || !out_valid_q || rsp_ready_i;
  assign load  = adv_o && s2_ctrl_i.valid;
  assign g_inc = gen_rdata_i + 1'b1;

  always_comb begin
    g_out = '0;
    alive = 1'b0;
    unique case (s2_ctrl_i.op)
      OP_ZERO, OP_FRESH: g_out = '0;
      OP_STORED:         g_out = gen_rdata_i;
      OP_DESTROY:        g_out = g_inc;
      OP_CHECK: begin
        g_out = gen_rdata_i;
        alive = GW'(s2_ctrl_i.gen) == GW'(gen_rdata_i);
      end
      default:           g_out = '0;
    endcase
  end

  assign gen_we_o    = load && ((s2_ctrl_i.op == OP_FRESH) || (s2_ctrl_i.op == OP_DESTROY));
  assign gen_waddr_o = s2_addr_i;
  assign gen_wdata_o = (s2_ctrl_i.op == OP_DESTROY) ? g_inc : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_index_q  <= s2_ctrl_i.index;
      out_gen_q    <= GEN_W'(GW'(g_out));
      out_alive_q  <= alive;
      out_status_q <= s2_ctrl_i.status;
    end
  end

  assign rsp_valid_o  = out_valid_q;
  assign rsp_index_o  = out_index_q;
  assign rsp_gen_o    = out_gen_q;
  assign rsp_alive_o  = out_alive_q;
  assign rsp_status_o = out_status_q;

endmodule

// File: src/gha_checker.sv
// Port-level assertions for the handle allocator, bound to the top level.
module gha_checker import gha_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             req_valid_i,
  input logic             req_ready_i,
  input logic             rsp_valid_i,
  input logic             rsp_ready_i,
  input logic [IDX_W-1:0] rsp_index_i,
  input logic [GEN_W-1:0] rsp_gen_i,
  input logic             rsp_alive_i,
  input logic [1:0]       rsp_status_i
);

  // stalled response holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_index_i) &&
      $stable(rsp_gen_i) && $stable(rsp_alive_i) && $stable(rsp_status_i))
    else $error("response changed while stalled");

  // an accepted request has a valid response once it has passed the input, issue and result registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |-> ##3 rsp_valid_i)
    else $error("no response three cycles after request");

  a_alive_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_alive_i |-> rsp_status_i == ST_OK)
    else $error("alive reported with error status");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i == ST_NO_SLOT || rsp_status_i == ST_NOT_ISSUED) |->
      rsp_gen_i == '0 && !rsp_alive_i)
    else $error("error response carries a generation");

endmodule

bind generational_handle_allocator_top gha_checker u_gha_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_index_i  (rsp_o.handle_index),
  .rsp_gen_i    (rsp_o.handle_generation),
  .rsp_alive_i  (rsp_o.is_alive),
  .rsp_status_i (rsp_o.status)
);
